FILE: rtl/core/pdc_pkg.sv
// pdc_pkg: types and constants shared by the deframer modules
// no dependencies
`timescale 1ns / 1ps

package pdc_pkg;

	localparam logic [7:0] HDR_FIRST   = 8'hFA;
	localparam logic [7:0] HDR_SECOND  = 8'hFB;
	localparam logic [7:0] MIN_LEN     = 8'd3;
	localparam logic [7:0] MAX_LEN_RST = 8'd204;
	localparam logic [7:0] CKSUM_BYTES = 8'd2;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_LEN,
		PH_BODY,
		PH_CKHI,
		PH_CKLO
	} phase_t;

	typedef enum logic [1:0] {
		OP_BODY,
		OP_BADLEN,
		OP_CKHI,
		OP_CKLO
	} op_kind_t;

	typedef enum logic [1:0] {
		ST_GOOD   = 2'd0,
		ST_CKSUM  = 2'd1,
		ST_BADLEN = 2'd2
	} status_t;

	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] data;
		logic [7:0] pos;
		logic       last;
	} cmd_t;

endpackage

FILE: rtl/core/pdc_rx_if.sv
// pdc_rx_if: valid/ready channel carrying one received serial byte
// no dependencies
`timescale 1ns / 1ps

interface pdc_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/core/pdc_res_if.sv
// pdc_res_if: valid/ready channel carrying body bytes and frame status
// no dependencies
`timescale 1ns / 1ps

interface pdc_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic [7:0] byte_pos;
	logic       frame_end;
	logic [1:0] frame_status;

	modport source (output valid, output data_byte, output byte_pos, output frame_end,
		output frame_status, input ready);
	modport sink (input valid, input data_byte, input byte_pos, input frame_end,
		input frame_status, output ready);
endinterface

FILE: rtl/core/pdc_front.sv
// pdc_front: header hunt, length check and byte classification
// depends on pdc_pkg and pdc_rx_if
`timescale 1ns / 1ps

module pdc_front
	import pdc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	pdc_rx_if.sink      rx,
	input  logic [7:0]  max_len,
	input  logic        full,
	output logic        push,
	output cmd_t        cmd
);

	phase_t     phase_q, phase_d;
	logic [7:0] prev_q, prev_d;
	logic [7:0] remain_q, remain_d;
	logic [7:0] pos_q, pos_d;
	logic       accept;
	logic       len_bad;
	logic       hdr_hit;

	assign rx.ready = !full;
	assign accept   = rx.valid && !full;
	assign len_bad  = (rx.rx_byte < MIN_LEN) || (rx.rx_byte > max_len);
	assign hdr_hit  = (prev_q == HDR_FIRST) && (rx.rx_byte == HDR_SECOND);

	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			case (phase_q)
				PH_LEN:  phase_d = len_bad ? PH_HUNT : PH_BODY;
				PH_BODY: phase_d = (remain_q == 8'd1) ? PH_CKHI : PH_BODY;
				PH_CKHI: phase_d = PH_CKLO;
				PH_CKLO: phase_d = PH_HUNT;
				default: phase_d = hdr_hit ? PH_LEN : PH_HUNT;
			endcase
		end
	end

	always_comb begin
		prev_d   = prev_q;
		remain_d = remain_q;
		pos_d    = pos_q;
		push     = 1'b0;
		cmd      = '{kind: OP_BODY, data: rx.rx_byte, pos: pos_q,
			last: (remain_q == 8'd1)};
		if (accept) begin
			case (phase_q)
				PH_LEN: begin
					if (len_bad) begin
						push     = 1'b1;
						cmd.kind = OP_BADLEN;
						prev_d   = 8'd0;
					end else begin
						remain_d = rx.rx_byte - CKSUM_BYTES;
						pos_d    = 8'd0;
					end
				end
				PH_BODY: begin
					push     = 1'b1;
					cmd.kind = OP_BODY;
					pos_d    = pos_q + 8'd1;
					remain_d = remain_q - 8'd1;
				end
				PH_CKHI: begin
					push     = 1'b1;
					cmd.kind = OP_CKHI;
				end
				PH_CKLO: begin
					push     = 1'b1;
					cmd.kind = OP_CKLO;
					prev_d   = 8'd0;
				end
				default: begin
					prev_d = hdr_hit ? 8'd0 : rx.rx_byte;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			prev_q   <= 8'd0;
			remain_q <= 8'd0;
			pos_q    <= 8'd0;
		end else begin
			phase_q  <= phase_d;
			prev_q   <= prev_d;
			remain_q <= remain_d;
			pos_q    <= pos_d;
		end
	end

endmodule

FILE: rtl/core/pdc_fifo.sv
// pdc_fifo: short command queue between front and back
// depends on pdc_pkg
`timescale 1ns / 1ps

module pdc_fifo
	import pdc_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output cmd_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/pdc_back.sv
// pdc_back: checksum accumulation, compare and registered result output
// depends on pdc_pkg and pdc_res_if
`timescale 1ns / 1ps

module pdc_back
	import pdc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        not_empty,
	input  cmd_t        head,
	output logic        pop,
	pdc_res_if.source   res
);

	logic [15:0] sum_q, sum_d;
	logic [7:0]  pend_q, pend_d;
	logic        half_q, half_d;
	logic [7:0]  ck_hi_q;
	logic        out_valid_q;
	logic [7:0]  data_q;
	logic [7:0]  pos_q;
	logic        end_q;
	status_t     status_q, status_d;
	logic        out_free;
	logic [15:0] base_sum;
	logic        base_half;

	assign out_free  = !out_valid_q || res.ready;
	assign pop       = not_empty && ((head.kind == OP_CKHI) || out_free);
	assign base_sum  = (head.pos == 8'd0) ? 16'd0 : sum_q;
	assign base_half = (head.pos == 8'd0) ? 1'b0 : half_q;

	always_comb begin
		sum_d  = base_sum;
		pend_d = pend_q;
		half_d = 1'b0;
		if (base_half) begin
			sum_d = base_sum + {pend_q, head.data};
		end else if (head.last) begin
			sum_d = base_sum ^ {8'd0, head.data};
		end else begin
			pend_d = head.data;
			half_d = 1'b1;
		end
	end

	always_comb begin
		case (head.kind)
			OP_BADLEN: status_d = ST_BADLEN;
			OP_CKLO:   status_d = ({ck_hi_q, head.data} == sum_q) ? ST_GOOD : ST_CKSUM;
			default:   status_d = ST_GOOD;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			case (head.kind)
				OP_BODY: begin
					sum_q  <= sum_d;
					pend_q <= pend_d;
					half_q <= half_d;
				end
				OP_CKHI: begin
					ck_hi_q <= head.data;
				end
				default: begin
				end
			endcase
			if (head.kind != OP_CKHI) begin
				data_q   <= (head.kind == OP_BODY) ? head.data : 8'd0;
				pos_q    <= (head.kind == OP_BODY) ? head.pos : 8'd0;
				end_q    <= (head.kind != OP_BODY);
				status_q <= status_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && (head.kind != OP_CKHI)) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.data_byte    = data_q;
	assign res.byte_pos     = pos_q;
	assign res.frame_end    = end_q;
	assign res.frame_status = status_q;

endmodule

FILE: rtl/core/packet_deframer_checksum.sv
// packet_deframer_checksum: top level of the serial frame deframer
// depends on pdc_pkg, pdc_rx_if, pdc_res_if, pdc_front, pdc_fifo, pdc_back
`timescale 1ns / 1ps

// Takes one byte per cycle from the serial side while the queue has room, hunts for the
// 0xFA 0xFB header, checks the length byte against max_len_q and passes each body byte
// on with its position, then closes the frame with a status transaction (0 good,
// 1 checksum mismatch, 2 bad length). Sustained rate is one byte per cycle while results
// are taken; each result passes through its queue entry and then the output register
// before it is offered. The front classifies bytes into a FIFO_DEPTH entry queue;
// rx_ch.ready drops only while that queue is full, which happens when the result side
// stalls. The queue lets new bytes in while a result waits in the output register.
module packet_deframer_checksum
	import pdc_pkg::*;
#(
	parameter int FIFO_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	pdc_rx_if.sink     rx_ch,
	pdc_res_if.source  res_ch,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data
);

	logic [7:0] max_len_q;
	logic       push;
	cmd_t       push_cmd;
	logic       full;
	logic       pop;
	logic       not_empty;
	cmd_t       head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RST;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	pdc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_ch),
		.max_len (max_len_q),
		.full    (full),
		.push    (push),
		.cmd     (push_cmd)
	);

	pdc_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	pdc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.res       (res_ch)
	);

	a_status_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res_ch.valid && res_ch.frame_end |-> res_ch.data_byte == 8'd0 && res_ch.byte_pos == 8'd0)
		else $error("status transaction carries body payload");

	a_body_good_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_ch.valid && !res_ch.frame_end |-> res_ch.frame_status == ST_GOOD)
		else $error("body transaction carries nonzero status");

	a_ready_follows_queue: assert property (@(posedge clk) disable iff (!arst_n)
		!rx_ch.ready |-> full && !$past(pop && !not_empty))
		else $error("input stalled while queue has room");

	a_push_not_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("command pushed into full queue");

endmodule

FILE: test/packet_deframer_checksum_tb.sv
// packet_deframer_checksum_tb: self-checking bench for the serial frame deframer
// drives bytes on pdc_rx_if, checks body bytes and frame status on pdc_res_if
// depends on pdc_pkg, pdc_rx_if, pdc_res_if and packet_deframer_checksum
`timescale 1ns / 1ps

module packet_deframer_checksum_tb;
	import pdc_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic [7:0] pos;
		logic       fend;
		status_t    status;
	} frame_result_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;

	pdc_rx_if  rx_ch();
	pdc_res_if res_ch();

	packet_deframer_checksum u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_ch       (rx_ch),
		.res_ch      (res_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	logic [7:0]    pending_bytes[$];
	frame_result_t expected_results[$];

	// deframer state mirrored from the accepted byte stream
	logic [7:0]  max_len_cfg;
	phase_t      deframe_phase;
	logic [7:0]  hunt_prev;
	logic [7:0]  body_left;
	logic [7:0]  body_pos;
	logic [15:0] body_sum;
	logic [7:0]  pair_high;
	logic        pair_open;
	logic [7:0]  sum_high_rx;

	int src_idle_pct;
	int snk_idle_pct;
	int src_gap;
	int snk_gap;
	int long_hold_left;
	logic long_hold_req;
	logic long_hold_done;

	int error_count = 0;
	int bytes_taken = 0;
	int body_bytes = 0;
	int good_frames = 0;
	int cksum_frames = 0;
	int badlen_frames = 0;

	int phase_limit[7];
	int phase_budget[7];
	int phase_src_idle[7];
	int phase_snk_idle[7];

	function automatic void predict_byte(input logic [7:0] rx);
		frame_result_t r;
		r = '0;
		case (deframe_phase)
			PH_LEN: begin
				if (rx < MIN_LEN || rx > max_len_cfg) begin
					r.fend = 1'b1;
					r.status = ST_BADLEN;
					expected_results.push_back(r);
					deframe_phase = PH_HUNT;
					hunt_prev = '0;
				end else begin
					body_left = rx - CKSUM_BYTES;
					body_pos = '0;
					body_sum = '0;
					pair_high = '0;
					pair_open = 1'b0;
					deframe_phase = PH_BODY;
				end
			end
			PH_BODY: begin
				r.data = rx;
				r.pos = body_pos;
				expected_results.push_back(r);
				if (!pair_open) begin
					pair_high = rx;
					pair_open = 1'b1;
				end else begin
					body_sum = body_sum + {pair_high, rx};
					pair_open = 1'b0;
				end
				body_pos = body_pos + 8'd1;
				body_left = body_left - 8'd1;
				if (body_left == 8'd0) begin
					if (pair_open)
						body_sum = body_sum ^ {8'h00, pair_high};
					pair_open = 1'b0;
					deframe_phase = PH_CKHI;
				end
			end
			PH_CKHI: begin
				sum_high_rx = rx;
				deframe_phase = PH_CKLO;
			end
			PH_CKLO: begin
				r.fend = 1'b1;
				r.status = ({sum_high_rx, rx} == body_sum) ? ST_GOOD : ST_CKSUM;
				expected_results.push_back(r);
				deframe_phase = PH_HUNT;
				hunt_prev = '0;
			end
			default: begin
				if (hunt_prev == HDR_FIRST && rx == HDR_SECOND) begin
					deframe_phase = PH_LEN;
					hunt_prev = '0;
				end else begin
					deframe_phase = PH_HUNT;
					hunt_prev = rx;
				end
			end
		endcase
	endfunction

	// fill < 0 gives a random body, otherwise every body byte is fill
	task automatic push_frame(input logic [7:0] len, input bit corrupt, input int fill);
		logic [15:0] sum;
		logic [7:0]  b;
		logic [7:0]  hi;
		bit          half;
		int          n;
		sum = '0;
		hi = '0;
		half = 1'b0;
		n = (len >= MIN_LEN) ? int'(len) - 2 : 0;
		pending_bytes.push_back(HDR_FIRST);
		pending_bytes.push_back(HDR_SECOND);
		pending_bytes.push_back(len);
		for (int i = 0; i < n; i++) begin
			b = (fill < 0) ? 8'($urandom) : 8'(fill);
			pending_bytes.push_back(b);
			if (!half) begin
				hi = b;
				half = 1'b1;
			end else begin
				sum = sum + {hi, b};
				half = 1'b0;
			end
		end
		if (half)
			sum = sum ^ {8'h00, hi};
		if (corrupt)
			sum = sum ^ (16'h0001 << $urandom_range(0, 15));
		pending_bytes.push_back(sum[15:8]);
		pending_bytes.push_back(sum[7:0]);
	endtask

	task automatic add_random_traffic(input int n_bytes);
		int         start;
		int         pick;
		int         cap;
		int         n;
		logic [7:0] len;
		start = pending_bytes.size();
		while (pending_bytes.size() - start < n_bytes) begin
			pick = $urandom_range(0, 99);
			cap = (max_len_cfg < 8'd24) ? int'(max_len_cfg) : 24;
			if ($urandom_range(0, 24) == 0)
				cap = max_len_cfg;
			if (cap < 3)
				cap = 24;
			len = 8'($urandom_range(3, cap));
			if (pick < 68) begin
				push_frame(len, $urandom_range(0, 6) == 0, -1);
			end else if (pick < 80) begin
				pending_bytes.push_back(HDR_FIRST);
				pending_bytes.push_back(HDR_SECOND);
				if (max_len_cfg == 8'hFF || $urandom_range(0, 1) == 0)
					pending_bytes.push_back(8'($urandom_range(0, 2)));
				else
					pending_bytes.push_back(8'($urandom_range(int'(max_len_cfg) + 1, 255)));
			end else if (pick < 90) begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					pending_bytes.push_back(($urandom_range(0, 3) == 0) ? HDR_FIRST :
						8'($urandom));
			end else begin
				// cut-off frame, later bytes finish its body
				pending_bytes.push_back(HDR_FIRST);
				pending_bytes.push_back(HDR_SECOND);
				pending_bytes.push_back(len);
				n = $urandom_range(0, int'(len) - 3);
				for (int i = 0; i < n; i++)
					pending_bytes.push_back(8'($urandom));
			end
		end
	endtask

	task automatic drain();
		do
			@(posedge clk);
		while (pending_bytes.size() != 0 || rx_ch.valid || expected_results.size() != 0);
		repeat (12) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("packet_deframer_checksum test failed");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin : driver
		if (!arst_n) begin
			rx_ch.valid <= 1'b0;
			rx_ch.rx_byte <= '0;
			src_gap <= 0;
		end else begin
			if (rx_ch.valid && rx_ch.ready) begin
				predict_byte(rx_ch.rx_byte);
				bytes_taken++;
			end
			if (rx_ch.valid && !rx_ch.ready) begin
				// hold the offered transaction
			end else if (src_gap != 0) begin
				src_gap <= src_gap - 1;
				rx_ch.valid <= 1'b0;
			end else if (pending_bytes.size() != 0 && $urandom_range(0, 99) < src_idle_pct) begin
				src_gap <= $urandom_range(0, 12);
				rx_ch.valid <= 1'b0;
			end else if (pending_bytes.size() != 0) begin
				rx_ch.valid <= 1'b1;
				rx_ch.rx_byte <= pending_bytes.pop_front();
			end else begin
				rx_ch.valid <= 1'b0;
			end
		end
	end

	// one long receiver stall, counted here while the sender keeps offering
	always @(posedge clk or negedge arst_n) begin : long_hold
		if (!arst_n) begin
			long_hold_left <= 0;
			long_hold_done <= 1'b0;
		end else if (long_hold_req && !long_hold_done) begin
			long_hold_left <= 80;
			long_hold_done <= 1'b1;
		end else if (long_hold_left != 0) begin
			long_hold_left <= long_hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		frame_result_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			snk_gap <= 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_results.size() == 0) begin
					$error({"unexpected transaction: data_byte %0h byte_pos %0d ",
						"frame_end %0b frame_status %0d"},
						res_ch.data_byte, res_ch.byte_pos, res_ch.frame_end,
						res_ch.frame_status);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					if (res_ch.data_byte !== want.data) begin
						$error("data_byte mismatch: expected %0h, got %0h", want.data,
							res_ch.data_byte);
						error_count++;
					end
					if (res_ch.byte_pos !== want.pos) begin
						$error("byte_pos mismatch: expected %0d, got %0d", want.pos,
							res_ch.byte_pos);
						error_count++;
					end
					if (res_ch.frame_end !== want.fend) begin
						$error("frame_end mismatch: expected %0b, got %0b", want.fend,
							res_ch.frame_end);
						error_count++;
					end
					if (res_ch.frame_status !== want.status) begin
						$error("frame_status mismatch: expected %0d, got %0d", want.status,
							res_ch.frame_status);
						error_count++;
					end
					if (!want.fend)
						body_bytes++;
					else if (want.status == ST_GOOD)
						good_frames++;
					else if (want.status == ST_CKSUM)
						cksum_frames++;
					else
						badlen_frames++;
				end
			end
			if ((long_hold_req && !long_hold_done) || long_hold_left != 0) begin
				res_ch.ready <= 1'b0;
			end else if (snk_gap != 0) begin
				snk_gap <= snk_gap - 1;
				res_ch.ready <= 1'b0;
			end else if ($urandom_range(0, 99) < snk_idle_pct) begin
				snk_gap <= $urandom_range(0, 12);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [7:0] next_limit;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		long_hold_req = 1'b0;
		src_idle_pct = 15;
		snk_idle_pct = 15;
		max_len_cfg = MAX_LEN_RST;
		deframe_phase = PH_HUNT;
		hunt_prev = '0;
		body_left = '0;
		body_pos = '0;
		body_sum = '0;
		pair_high = '0;
		pair_open = 1'b0;
		sum_high_rx = '0;

		phase_limit = '{204, 255, 3, 0, 2, -1, 204};
		phase_budget = '{35, 25, 35, 30, 30, 35, 35};
		phase_src_idle = '{15, 0, 20, 10, 25, 8, 0};
		phase_snk_idle = '{15, 10, 0, 25, 10, 20, 0};

		// repeated header start, shortest frame with odd body, too-short and zero lengths,
		// oversize length then a lone second header byte, checksum mismatch ending in
		// a header start byte that must not pair with the next byte
		pending_bytes = '{HDR_FIRST, HDR_FIRST, HDR_SECOND, 8'd3, 8'hFF, 8'h00, 8'hFF,
			HDR_FIRST, HDR_SECOND, 8'd2,
			HDR_FIRST, HDR_SECOND, 8'd0,
			HDR_FIRST, HDR_SECOND, HDR_FIRST, HDR_SECOND,
			HDR_FIRST, HDR_SECOND, 8'd4, 8'hFF, 8'hFF, 8'hFF, HDR_FIRST, HDR_SECOND};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		drain();

		for (int p = 0; p < 7; p++) begin
			next_limit = (phase_limit[p] < 0) ? 8'($urandom_range(3, 254)) :
				8'(phase_limit[p]);
			@(posedge clk);
			cfg_wr_en <= 1'b1;
			cfg_wr_data <= next_limit;
			@(posedge clk);
			cfg_wr_en <= 1'b0;
			max_len_cfg = next_limit;
			src_idle_pct = phase_src_idle[p];
			snk_idle_pct = phase_snk_idle[p];
			if (p == 1)
				long_hold_req <= 1'b1;
			if (max_len_cfg >= MIN_LEN)
				push_frame(max_len_cfg, 1'b0, (p == 0) ? 0 : -1);
			if (max_len_cfg != 8'hFF) begin
				pending_bytes.push_back(HDR_FIRST);
				pending_bytes.push_back(HDR_SECOND);
				pending_bytes.push_back(max_len_cfg + 8'd1);
			end
			add_random_traffic(phase_budget[p]);
			drain();
		end

		repeat (20) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d expected transactions never arrived", expected_results.size());
			error_count++;
		end
		$display("sent %0d serial bytes under 8 length limits; %0d body bytes checked",
			bytes_taken, body_bytes);
		$display("frames closed: %0d good, %0d checksum errors, %0d bad lengths",
			good_frames, cksum_frames, badlen_frames);
		if (error_count == 0)
			$display("packet_deframer_checksum test passed");
		else
			$display("packet_deframer_checksum test failed");
		$finish;
	end

endmodule
